// ===== src/e8_lattice_decoder_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef E8_LATTICE_DECODER_UNIT_ASSERT_SVH
`define E8_LATTICE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define E8LD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define E8LD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/e8ld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8ld_pkg
// Shared constants and the message remap of the E8 lattice decoder.
// ----------------------------------------------------------------------------
package e8ld_pkg;

  // coefficient and message geometry
  localparam int unsigned COEF_W      = 10;
  localparam int unsigned NUM_COEF    = 8;
  localparam int unsigned NUM_PAIR    = NUM_COEF / 2;
  localparam int unsigned D8_W        = 4;
  localparam int unsigned MSG_W       = 4;

  // default modulus, power of two from 16 to 65536
  localparam int unsigned MODULUS_DEF = 1024;

  // D8 bits to the upper message bits: {b3, b1^b0, b0}
  function automatic logic [MSG_W-2:0] remap_bits(input logic [D8_W-1:0] b);
    logic [MSG_W-2:0] r;
    r = {b[3], b[1] ^ b[0], b[0]};
    return r;
  endfunction

endpackage

// ===== src/e8ld_cost.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8ld_cost
// Squared circular distance of one coefficient to 0 and to half the modulus.
// ----------------------------------------------------------------------------
module e8ld_cost #(
  parameter int unsigned MODULUS = e8ld_pkg::MODULUS_DEF
) (
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_i,
  output logic [2*$clog2(MODULUS)-1:0]   cost_zero_o,
  output logic [2*$clog2(MODULUS)-1:0]   cost_half_o
);

  localparam int unsigned ModW = $clog2(MODULUS);
  localparam int unsigned XW   = ModW + 1;
  localparam int unsigned SqW  = 2 * ModW;
  localparam logic [XW-1:0] Mod  = XW'(MODULUS);
  localparam logic [XW-1:0] Half = XW'(MODULUS / 2);

  logic [XW-1:0]   x;
  logic [ModW-1:0] dist_zero;
  logic [ModW-1:0] dist_half;

  // reduce modulo the modulus by keeping the low bits
  if (ModW < e8ld_pkg::COEF_W) begin : g_narrow
    assign x = {1'b0, coef_i[ModW-1:0]};
  end else begin : g_wide
    assign x = XW'(coef_i);
  end

  // circular distance to 0 and plain distance to half
  always_comb begin
    dist_zero = (x > Half) ? ModW'(Mod - x) : ModW'(x);
    dist_half = (x >= Half) ? ModW'(x - Half) : ModW'(Half - x);
  end

  // squares
  assign cost_zero_o = SqW'(dist_zero) * SqW'(dist_zero);
  assign cost_half_o = SqW'(dist_half) * SqW'(dist_half);

endmodule

// ===== src/e8ld_coset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8ld_coset
// Decodes one D8 coset: pairwise hard decisions and parity repair.
// ----------------------------------------------------------------------------
module e8ld_coset #(
  parameter int unsigned PairW = 2 * $clog2(e8ld_pkg::MODULUS_DEF) + 1
) (
  input  logic [PairW-1:0]              zero_cost_i [e8ld_pkg::NUM_PAIR],
  input  logic [PairW-1:0]              one_cost_i  [e8ld_pkg::NUM_PAIR],
  output logic [e8ld_pkg::D8_W-1:0]     bits_o,
  output logic [PairW+2:0]              total_o
);

  localparam int unsigned TW = PairW + 3;

  logic [e8ld_pkg::NUM_PAIR-1:0] hard;
  logic [PairW-1:0]              win  [e8ld_pkg::NUM_PAIR];
  logic [PairW-1:0]              pen  [e8ld_pkg::NUM_PAIR];
  logic [TW-1:0]                 sum;
  logic [PairW-1:0]              best_pen;
  logic [$clog2(e8ld_pkg::NUM_PAIR)-1:0] best_idx;
  logic                          parity;

  // per-pair decision, winning cost and flip penalty
  always_comb begin
    for (int i = 0; i < e8ld_pkg::NUM_PAIR; i++) begin
      hard[i] = one_cost_i[i] < zero_cost_i[i];
      win[i]  = hard[i] ? one_cost_i[i] : zero_cost_i[i];
      pen[i]  = hard[i] ? (zero_cost_i[i] - one_cost_i[i])
                        : (one_cost_i[i] - zero_cost_i[i]);
    end
  end

  // total of the chosen costs
  always_comb begin
    sum = '0;
    for (int i = 0; i < e8ld_pkg::NUM_PAIR; i++) begin
      sum = sum + TW'(win[i]);
    end
  end

  // cheapest flip, lowest pair on ties
  always_comb begin
    best_pen = pen[0];
    best_idx = '0;
    for (int i = 1; i < e8ld_pkg::NUM_PAIR; i++) begin
      if (pen[i] < best_pen) begin
        best_pen = pen[i];
        best_idx = ($clog2(e8ld_pkg::NUM_PAIR))'(i);
      end
    end
  end

  // parity repair
  assign parity  = ^hard;
  assign bits_o  = parity ? (hard ^ (e8ld_pkg::D8_W'(1) << best_idx)) : hard;
  assign total_o = parity ? (sum + TW'(best_pen)) : sum;

endmodule

// ===== src/e8_lattice_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8_lattice_decoder_unit
// Nearest E8 point of eight coefficients, returned as a 4-bit message.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+-----------------------------
//  in      | in_valid_i, in_ready_o           | coef_0_i .. coef_7_i
//  out     | out_valid_o, out_ready_i         | message_o
//
// two register stages: input register, then the result register; the
// distance squares, coset decoding and selection sit between them.
// one beat per cycle while the output is not stalled.
// a stalled output holds the result and backs up through the input stage.
// rst_ni clears only the valid flags; no state is kept between beats.
// ----------------------------------------------------------------------------
module e8_lattice_decoder_unit #(
  parameter int unsigned MODULUS = e8ld_pkg::MODULUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_0_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_1_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_2_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_3_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_4_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_5_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_6_i,
  input  logic [e8ld_pkg::COEF_W-1:0]    coef_7_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [e8ld_pkg::MSG_W-1:0]     message_o
);

  localparam int unsigned SqW   = 2 * $clog2(MODULUS);
  localparam int unsigned PairW = SqW + 1;
  localparam int unsigned TW    = PairW + 3;

  logic [e8ld_pkg::COEF_W-1:0] coef_in [e8ld_pkg::NUM_COEF];
  logic [e8ld_pkg::COEF_W-1:0] coef_q  [e8ld_pkg::NUM_COEF];
  logic                        in_vld_q;
  logic                        out_vld_q;
  logic [e8ld_pkg::MSG_W-1:0]  msg_q;
  logic [e8ld_pkg::MSG_W-1:0]  msg_d;
  logic                        res_ready;

  logic [SqW-1:0]   c_zero [e8ld_pkg::NUM_COEF];
  logic [SqW-1:0]   c_half [e8ld_pkg::NUM_COEF];
  logic [PairW-1:0] zero_a [e8ld_pkg::NUM_PAIR];
  logic [PairW-1:0] one_a  [e8ld_pkg::NUM_PAIR];
  logic [PairW-1:0] zero_b [e8ld_pkg::NUM_PAIR];
  logic [PairW-1:0] one_b  [e8ld_pkg::NUM_PAIR];
  logic [e8ld_pkg::D8_W-1:0] bits_a;
  logic [e8ld_pkg::D8_W-1:0] bits_b;
  logic [TW-1:0]    total_a;
  logic [TW-1:0]    total_b;
  logic             sel;

  // gather the beat
  assign coef_in[0] = coef_0_i;
  assign coef_in[1] = coef_1_i;
  assign coef_in[2] = coef_2_i;
  assign coef_in[3] = coef_3_i;
  assign coef_in[4] = coef_4_i;
  assign coef_in[5] = coef_5_i;
  assign coef_in[6] = coef_6_i;
  assign coef_in[7] = coef_7_i;

  // handshake: each stage advances when the next one is free
  assign res_ready  = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || res_ready;

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      coef_q <= coef_in;
    end
  end

  // per-coefficient costs
  for (genvar g = 0; g < e8ld_pkg::NUM_COEF; g++) begin : g_cost
    e8ld_cost #(
      .MODULUS (MODULUS)
    ) u_cost (
      .coef_i      (coef_q[g]),
      .cost_zero_o (c_zero[g]),
      .cost_half_o (c_half[g])
    );
  end

  // pair costs for offsets 00 and 10
  always_comb begin
    for (int i = 0; i < e8ld_pkg::NUM_PAIR; i++) begin
      zero_a[i] = PairW'(c_zero[2*i]) + PairW'(c_zero[2*i+1]);
      one_a[i]  = PairW'(c_half[2*i]) + PairW'(c_half[2*i+1]);
      zero_b[i] = PairW'(c_half[2*i]) + PairW'(c_zero[2*i+1]);
      one_b[i]  = PairW'(c_zero[2*i]) + PairW'(c_half[2*i+1]);
    end
  end

  e8ld_coset #(
    .PairW (PairW)
  ) u_coset_a (
    .zero_cost_i (zero_a),
    .one_cost_i  (one_a),
    .bits_o      (bits_a),
    .total_o     (total_a)
  );

  e8ld_coset #(
    .PairW (PairW)
  ) u_coset_b (
    .zero_cost_i (zero_b),
    .one_cost_i  (one_b),
    .bits_o      (bits_b),
    .total_o     (total_b)
  );

  // cheaper coset wins, offset 00 on ties
  assign sel   = total_b < total_a;
  assign msg_d = {e8ld_pkg::remap_bits(sel ? bits_b : bits_a), sel};

  // result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (res_ready && in_vld_q) begin
      msg_q <= msg_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign message_o   = msg_q;

endmodule

// ===== src/e8ld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8ld_checker
// Port-level checks of the E8 lattice decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "e8_lattice_decoder_unit_assert.svh"

module e8ld_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [e8ld_pkg::MSG_W-1:0]     message_o
);

  // a stalled result beat holds
  `E8LD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(message_o), "result beat changed while stalled")

  // an empty result stage never blocks the input
  `E8LD_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o, "input blocked with empty result stage")

  // a draining output never blocks the input
  `E8LD_ASSERT_IMP(a_drain_ready, out_ready_i, in_ready_o, "input blocked while output drains")

  // an accepted beat reaches the output through the input and result registers when not stalled
  `E8LD_ASSERT_NXT(a_latency, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o, "accepted beat did not reach the output")

endmodule

bind e8_lattice_decoder_unit e8ld_checker u_e8ld_checker (.*);

// ===== bench/tb_e8_lattice_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_e8_lattice_decoder_unit
// Self-checking bench for the E8 lattice decoder over two D8 cosets.
// Eight coefficients go in per beat, one 4-bit message comes out. A local
// nearest-point model predicts each message; results are checked in order.
// Directed corners come first, then structured and uniform random beats,
// with random gaps on both channels in the first two of three idling phases.
// ----------------------------------------------------------------------------
module tb_e8_lattice_decoder_unit;

  localparam int unsigned MOD_VAL    = e8ld_pkg::MODULUS_DEF;
  localparam int unsigned HALF_VAL   = MOD_VAL / 2;
  localparam int unsigned LAT_CYCLES = 2;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef logic [e8ld_pkg::NUM_COEF-1:0][e8ld_pkg::COEF_W-1:0] coef_vec_t;
  typedef logic [e8ld_pkg::MSG_W-1:0]                          msg_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [e8ld_pkg::COEF_W-1:0] coef_i [e8ld_pkg::NUM_COEF];
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  msg_t                        message_o;

  msg_t              msg_expected_q [$];
  msg_t              msg_head;
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt    = 0;
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_idle_pct  = 0;

  initial begin
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) coef_i[i] = '0;
  end

  // clock
  always #5 clk_i = ~clk_i;

  e8_lattice_decoder_unit #(
    .MODULUS     (MOD_VAL)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .coef_0_i    (coef_i[0]),
    .coef_1_i    (coef_i[1]),
    .coef_2_i    (coef_i[2]),
    .coef_3_i    (coef_i[3]),
    .coef_4_i    (coef_i[4]),
    .coef_5_i    (coef_i[5]),
    .coef_6_i    (coef_i[6]),
    .coef_7_i    (coef_i[7]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .message_o   (message_o)
  );

  // nearest E8 point: best of the two D8 cosets, then remap into the message
  function automatic msg_t e8_nearest_message(input coef_vec_t coefs);
    longint unsigned dist_zero [e8ld_pkg::NUM_COEF];
    longint unsigned dist_half [e8ld_pkg::NUM_COEF];
    longint unsigned coset_cost [2];
    logic [e8ld_pkg::D8_W-1:0] coset_bits [2];
    longint unsigned c_zero, c_one, c_win, c_lose, best_pen;
    int unsigned     x, d, best_idx;
    logic            par, pick, sel;
    logic [e8ld_pkg::D8_W-1:0] b, mix;
    // squared circular distance to zero and squared distance to half
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) begin
      x = coefs[i] & (MOD_VAL - 1);
      d = (2 * x > MOD_VAL) ? MOD_VAL - x : x;
      dist_zero[i] = 64'(d) * 64'(d);
      d = (x >= HALF_VAL) ? x - HALF_VAL : HALF_VAL - x;
      dist_half[i] = 64'(d) * 64'(d);
    end
    // coset 0 is offset 00, coset 1 is offset 10
    for (int s = 0; s < 2; s++) begin
      coset_bits[s] = '0;
      coset_cost[s] = 0;
      par           = 1'b0;
      best_pen      = 0;
      best_idx      = 0;
      for (int p = 0; p < e8ld_pkg::NUM_PAIR; p++) begin
        if (s == 1) begin
          c_zero = dist_half[2*p] + dist_zero[2*p+1];
          c_one  = dist_zero[2*p] + dist_half[2*p+1];
        end else begin
          c_zero = dist_zero[2*p] + dist_zero[2*p+1];
          c_one  = dist_half[2*p] + dist_half[2*p+1];
        end
        pick             = (c_one < c_zero);
        coset_bits[s][p] = pick;
        par              = par ^ pick;
        c_win            = pick ? c_one : c_zero;
        c_lose           = pick ? c_zero : c_one;
        coset_cost[s]   += c_win;
        // strict compare keeps the lowest pair on equal penalties
        if (p == 0 || (c_lose - c_win) < best_pen) begin
          best_pen = c_lose - c_win;
          best_idx = p;
        end
      end
      // odd parity: flip the cheapest pair
      if (par) begin
        coset_bits[s][best_idx] = ~coset_bits[s][best_idx];
        coset_cost[s]          += best_pen;
      end
    end
    // equal costs keep coset 00
    sel = (coset_cost[1] < coset_cost[0]);
    b   = sel ? coset_bits[1] : coset_bits[0];
    mix = ((b ^ (b << 1)) & 4'b0011) | ((b >> 1) & 4'b0100);
    return {mix[2:0], sel};
  endfunction

  task automatic report_mismatch(input string what, input msg_t got, input msg_t want);
    mismatch_cnt++;
    $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // drive one beat, hold it until accepted, then queue its message
  task automatic push_coef_beat(input coef_vec_t coefs);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) coef_i[i] <= coefs[i];
    do @(posedge clk_i); while (!in_ready_o);
    msg_expected_q.push_back(e8_nearest_message(coefs));
  endtask

  // stop sending until every queued message has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (msg_expected_q.size() != 0) @(posedge clk_i);
    repeat (LAT_CYCLES + 2) @(posedge clk_i);
  endtask

  function automatic coef_vec_t fill_coefs(input int unsigned v);
    coef_vec_t c;
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = v[e8ld_pkg::COEF_W-1:0];
    return c;
  endfunction

  // corners: field extremes, exact half, ties, parity flips, coset choice
  task automatic test_directed_corners();
    coef_vec_t c;
    push_coef_beat(fill_coefs(0));
    push_coef_beat(fill_coefs(1023));
    push_coef_beat(fill_coefs(HALF_VAL));
    push_coef_beat(fill_coefs(256));   // each coefficient equidistant, cosets tie
    push_coef_beat(fill_coefs(768));
    push_coef_beat(fill_coefs(1));
    push_coef_beat(fill_coefs(511));
    push_coef_beat(fill_coefs(513));
    push_coef_beat(fill_coefs(10'h2AA));
    push_coef_beat(fill_coefs(10'h155));
    // one pair at half: odd parity, all penalties equal, lowest pair flips
    c = fill_coefs(0);
    c[0] = 10'(HALF_VAL); c[1] = 10'(HALF_VAL);
    push_coef_beat(c);
    // two pairs at half: even parity
    c[2] = 10'(HALF_VAL); c[3] = 10'(HALF_VAL);
    push_coef_beat(c);
    // single coefficient at half
    c = fill_coefs(0);
    c[0] = 10'(HALF_VAL);
    push_coef_beat(c);
    // alternating patterns favor the offset-10 coset
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = (i % 2 == 0) ? 10'(HALF_VAL) : 10'(0);
    push_coef_beat(c);
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = (i % 2 == 0) ? 10'(0) : 10'(HALF_VAL);
    push_coef_beat(c);
    // odd parity in coset 10, cheapest pair not the first
    for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = (i % 2 == 0) ? 10'(HALF_VAL) : 10'(0);
    c[4] = 10'd60; c[5] = 10'd500;
    push_coef_beat(c);
    // uneven penalties near the decision boundary
    c = fill_coefs(5);
    c[2] = 10'd300; c[3] = 10'd290; c[6] = 10'd280; c[7] = 10'd270;
    push_coef_beat(c);
    // wrap-around distances near the top of the range
    c = fill_coefs(1000);
    c[1] = 10'd24; c[5] = 10'd700;
    push_coef_beat(c);
    // walking ones over all bit positions
    for (int k = 0; k < e8ld_pkg::COEF_W; k += 2) begin
      for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) begin
        c[i] = 10'(1 << ((k + i) % e8ld_pkg::COEF_W));
      end
      push_coef_beat(c);
    end
  endtask

  // points near a lattice point: random coset, bits and parity plus noise
  task automatic test_lattice_points(input int unsigned n);
    coef_vec_t   c;
    logic [3:0]  b;
    logic        off;
    int unsigned noise, base;
    for (int j = 0; j < n; j++) begin
      off = 1'($urandom_range(0, 1));
      b   = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       noise = 8;
        1:       noise = 64;
        2:       noise = 200;
        default: noise = 255;
      endcase
      for (int p = 0; p < e8ld_pkg::NUM_PAIR; p++) begin
        for (int h = 0; h < 2; h++) begin
          if (off) base = ((h == 0) ^ b[p]) ? HALF_VAL : 0;
          else     base = b[p] ? HALF_VAL : 0;
          c[2*p+h] = 10'(base + MOD_VAL + $urandom_range(0, 2 * noise) - noise);
        end
      end
      push_coef_beat(c);
    end
  endtask

  task automatic test_uniform_coefs(input int unsigned n);
    coef_vec_t c;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = 10'($urandom_range(0, 1023));
      push_coef_beat(c);
    end
  endtask

  // coarse grid values give many equal costs and equal penalties
  task automatic test_grid_ties(input int unsigned n);
    coef_vec_t c;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < e8ld_pkg::NUM_COEF; i++) c[i] = 10'($urandom_range(0, 7) * 128);
      push_coef_beat(c);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (msg_expected_q.size() == 0) begin
        report_mismatch("message beat with nothing pending", message_o, '0);
      end else begin
        msg_head = msg_expected_q.pop_front();
        if (message_o !== msg_head) report_mismatch("message", message_o, msg_head);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // phase one: sender idles less than receiver
    tx_idle_pct = 34;
    rx_idle_pct = 49;
    test_directed_corners();
    test_lattice_points(150);
    wait_drained();

    // phase two: roles swapped
    tx_idle_pct = 49;
    rx_idle_pct = 34;
    test_uniform_coefs(150);
    test_grid_ties(70);

    // phase three: back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_lattice_points(150);
    test_uniform_coefs(100);

    wait_drained();
    repeat (LAT_CYCLES + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
